### design/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/dwpt_pkg.sv
package dwpt_pkg;

  // ring store
  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int MIN_KEEP_CM = 100;

  // field widths
  localparam int CM_W      = 20;
  localparam int MS_W      = 24;
  localparam int TOT_W     = 40;
  localparam int OUT_SUM_W = 32;

  // window sums hold every entry exactly, at least one bit above the output width
  localparam int WSUM_CM_W = (CM_W + ADDR_W > OUT_SUM_W) ? CM_W + ADDR_W : OUT_SUM_W + 1;
  localparam int WSUM_MS_W = (MS_W + ADDR_W > WSUM_CM_W) ? MS_W + ADDR_W : WSUM_CM_W;

  // configuration registers
  localparam int UNIT_W     = 11;
  localparam int SHORT_W    = 10;
  localparam int STEP_W     = 7;
  localparam int CFG_DATA_W = UNIT_W;
  localparam int CFG_IDX_W  = 4;
  localparam int TGT_W      = 18;

  localparam logic [UNIT_W-1:0]  UNIT_RST   = UNIT_W'(1000);
  localparam logic [SHORT_W-1:0] SHORT_RST  = SHORT_W'(100);
  localparam logic [STEP_W-1:0]  SPEECH_RST = STEP_W'(5);
  localparam logic [STEP_W-1:0]  HAPTIC_RST = STEP_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UNIT_LENGTH  = 4'd0,
    CFG_SHORT_WINDOW = 4'd1,
    CFG_SPEECH_STEP  = 4'd2,
    CFG_HAPTIC_STEP  = 4'd3
  } cfg_idx_e;

  // shared divider: four quotient bits per cycle
  localparam int DIVD_W         = TOT_W;
  localparam int DSR_W          = UNIT_W + 4;
  localparam int DIV_RADIX_BITS = 4;
  localparam int DIV_STEPS      = DIVD_W / DIV_RADIX_BITS;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS + 1);

  // milestone arithmetic
  localparam int DELTA_W = CM_W + 1;
  localparam int DQ_W    = DELTA_W;
  localparam int EV_W    = DQ_W + 1;

  typedef struct packed {
    logic [CM_W-1:0] cm;
    logic [MS_W-1:0] ms;
  } entry_t;

  typedef struct packed {
    logic [ADDR_W-1:0]    head;
    logic [CNT_W-1:0]     count;
    logic [WSUM_CM_W-1:0] cm;
    logic [WSUM_MS_W-1:0] ms;
  } win_t;

  localparam logic WIN_SHORT = 1'b0;
  localparam logic WIN_LONG  = 1'b1;

  function automatic logic [OUT_SUM_W-1:0] sat_out(input logic [WSUM_MS_W-1:0] v);
    logic [OUT_SUM_W-1:0] r;
    if (|v[WSUM_MS_W-1:OUT_SUM_W]) begin
      r = '1;
    end else begin
      r = v[OUT_SUM_W-1:0];
    end
    return r;
  endfunction

endpackage

### design/dwpt_div.sv
module dwpt_div import dwpt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVD_W-1:0] dividend_i,
  input  logic [DSR_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [DIVD_W-1:0] quot_o,
  output logic [DSR_W-1:0]  rem_o
);

  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 done_q;
  logic [DIVD_W-1:0]    quot_q, quot_d;
  logic [DSR_W-1:0]     rem_q, rem_d;
  logic [DSR_W-1:0]     divisor_q;

  // restoring division, radix 16
  always_comb begin
    logic [DSR_W:0]    r;
    logic [DIVD_W-1:0] q;
    q = quot_q;
    r = {1'b0, rem_q};
    for (int k = 0; k < DIV_RADIX_BITS; k++) begin
      r = {r[DSR_W-1:0], q[DIVD_W-1]};
      q = {q[DIVD_W-2:0], 1'b0};
      if (r >= {1'b0, divisor_q}) begin
        r    = r - {1'b0, divisor_q};
        q[0] = 1'b1;
      end
    end
    quot_d = q;
    rem_d  = r[DSR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= DIV_CNT_W'(DIV_STEPS);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == DIV_CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q    <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

### design/distance_window_pace_tracker_unit.sv
// sequence: four divider passes, then a read and pop of the oldest entry when the store is full,
//   the store write and a trim pass over each window; a zero-distance request answers in the next cycle
// throughput: a new request is taken in the result cycle and not before; the shared radix-16 divider
//   (four passes), the single store read port, the full-store pop and each trimmed entry set the pace
// reset: asynchronous, active low; clears indexes, counts, totals, window sums and flags and
//   loads the register defaults; the store itself is not cleared and needs no clearing pass
`include "assert_macros.svh"

module distance_window_pace_tracker_unit import dwpt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // register write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // command handshake
  input  logic                  start,
  output logic                  busy,
  output logic                  done_o,
  input  logic [CM_W-1:0]       increment_cm_i,
  input  logic [MS_W-1:0]       increment_ms_i,
  // result
  output logic [TOT_W-1:0]      total_distance_cm_o,
  output logic [TOT_W-1:0]      total_time_ms_o,
  output logic [OUT_SUM_W-1:0]  short_sum_cm_o,
  output logic [OUT_SUM_W-1:0]  short_sum_ms_o,
  output logic [OUT_SUM_W-1:0]  long_sum_cm_o,
  output logic [OUT_SUM_W-1:0]  long_sum_ms_o,
  output logic                  speech_event_o,
  output logic                  haptic_event_o,
  output logic                  entry_dropped_o
);

  typedef enum logic [10:0] {
    S_IDLE       = 11'b000_0000_0001,
    S_DIV_LAST   = 11'b000_0000_0010,  // total / (10 * unit) before this increment
    S_DIV_DELTA  = 11'b000_0000_0100,  // (remainder + added distance) / (10 * unit)
    S_DIV_SPEECH = 11'b000_0000_1000,  // last tenths count mod speech step
    S_DIV_HAPTIC = 11'b000_0001_0000,  // last tenths count mod haptic step
    S_FULL_RD    = 11'b000_0010_0000,  // read oldest entry before it is overwritten
    S_FULL_POP   = 11'b000_0100_0000,
    S_WRITE      = 11'b000_1000_0000,  // store write and window append
    S_WIN_RD     = 11'b001_0000_0000,  // read current window head
    S_WIN_EV     = 11'b010_0000_0000,  // trim loop, one pop per cycle
    S_RESP       = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [UNIT_W-1:0]  unit_q;
  logic [SHORT_W-1:0] short_win_q;
  logic [STEP_W-1:0]  speech_step_q;
  logic [STEP_W-1:0]  haptic_step_q;

  // request payload
  logic [CM_W-1:0] cm_q;
  logic [MS_W-1:0] ms_q;

  // tracker state
  logic [ADDR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0]  live_q, live_d;
  logic [TOT_W-1:0]  total_cm_q, total_cm_d;
  logic [TOT_W-1:0]  total_ms_q, total_ms_d;
  win_t              win_q [2];
  win_t              win_d [2];
  logic              sel_q, sel_d;
  logic [DIVD_W-1:0] last_t_q, last_t_d;
  logic [DQ_W-1:0]   dq_q, dq_d;
  logic              speech_q, speech_d;
  logic              haptic_q, haptic_d;
  logic              dropped_q, dropped_d;

  // ring store, one write and one registered read port
  entry_t            mem [STORE_DEPTH];
  entry_t            rd_data_q;
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr;

  // divider hookup
  logic              div_start, div_done;
  logic [DIVD_W-1:0] div_dividend, div_quot;
  logic [DSR_W-1:0]  div_divisor, div_rem;

  logic                 accept;
  logic                 full;
  logic [UNIT_W-1:0]    unit_nz;
  logic [DSR_W-1:0]     unit_div;
  logic [TGT_W-1:0]     short_tgt, long_tgt, tgt_cur;
  logic [TOT_W:0]       cm_sum, ms_sum;
  logic [TOT_W-1:0]     new_total_cm, new_total_ms;
  logic [DELTA_W-1:0]   delta;
  win_t                 win_cur;
  logic                 pop_ok;

  function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] i);
    return (i == ADDR_W'(STORE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  assign accept      = start && !busy;
  assign busy        = !((state_q == S_IDLE) || (state_q == S_RESP));
  assign done_o      = (state_q == S_RESP);
  assign cfg_ready_o = 1'b1;
  assign full        = (live_q >= CNT_W'(STORE_DEPTH));

  // a unit length of zero counts as one for the tenths count
  assign unit_nz   = (unit_q == '0) ? UNIT_W'(1) : unit_q;
  assign unit_div  = DSR_W'(unit_nz) * DSR_W'(10);
  assign short_tgt = TGT_W'(short_win_q) * TGT_W'(100);
  assign long_tgt  = TGT_W'(unit_q) * TGT_W'(100);

  // saturating totals after this increment
  assign cm_sum       = {1'b0, total_cm_q} + (TOT_W + 1)'(cm_q);
  assign ms_sum       = {1'b0, total_ms_q} + (TOT_W + 1)'(ms_q);
  assign new_total_cm = cm_sum[TOT_W] ? '1 : cm_sum[TOT_W-1:0];
  assign new_total_ms = ms_sum[TOT_W] ? '1 : ms_sum[TOT_W-1:0];
  assign delta        = DELTA_W'(new_total_cm - total_cm_q);

  // window under trim and its drop test against the head entry just read
  assign win_cur = win_q[sel_q];
  assign tgt_cur = (sel_q == WIN_LONG) ? long_tgt : short_tgt;
  assign pop_ok  = (win_cur.count > CNT_W'(1))
                && (win_cur.cm > WSUM_CM_W'(tgt_cur))
                && ((win_cur.cm - WSUM_CM_W'(rd_data_q.cm)) > WSUM_CM_W'(MIN_KEEP_CM));

  // divider operand selection, a new pass starts as the previous one finishes
  always_comb begin
    div_start    = 1'b0;
    div_dividend = total_cm_q;
    div_divisor  = unit_div;
    unique case (state_q)
      S_IDLE, S_RESP: begin
        div_start = accept && (increment_cm_i != '0);
      end
      S_DIV_LAST: begin
        div_start    = div_done;
        div_dividend = DIVD_W'(div_rem) + DIVD_W'(delta);
      end
      S_DIV_DELTA: begin
        div_start    = div_done;
        div_dividend = last_t_q;
        div_divisor  = DSR_W'(speech_step_q);
      end
      S_DIV_SPEECH: begin
        div_start    = div_done;
        div_dividend = last_t_q;
        div_divisor  = DSR_W'(haptic_step_q);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  dwpt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // store port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = win_cur.head;
    wr_en   = 1'b0;
    unique case (state_q)
      S_FULL_RD: begin
        // when full the oldest entry sits at the write slot
        rd_en   = 1'b1;
        rd_addr = tail_q;
      end
      S_WIN_RD: begin
        rd_en = 1'b1;
      end
      S_WIN_EV: begin
        // fetch the next head while popping the current one
        rd_en   = pop_ok;
        rd_addr = next_slot(win_cur.head);
      end
      S_WRITE: begin
        wr_en = 1'b1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[tail_q] <= '{cm: cm_q, ms: ms_q};
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    tail_d     = tail_q;
    live_d     = live_q;
    total_cm_d = total_cm_q;
    total_ms_d = total_ms_q;
    win_d      = win_q;
    sel_d      = sel_q;
    last_t_d   = last_t_q;
    dq_d       = dq_q;
    speech_d   = speech_q;
    haptic_d   = haptic_q;
    dropped_d  = dropped_q;

    unique case (state_q)
      S_IDLE, S_RESP: begin
        if (state_q == S_RESP) begin
          live_d  = (win_q[WIN_SHORT].count > win_q[WIN_LONG].count)
                  ? win_q[WIN_SHORT].count : win_q[WIN_LONG].count;
          state_d = S_IDLE;
        end
        if (accept) begin
          speech_d  = 1'b0;
          haptic_d  = 1'b0;
          dropped_d = 1'b0;
          // zero distance clears the event flags, leaves totals and windows as they are and just reports
          state_d   = (increment_cm_i == '0) ? S_RESP : S_DIV_LAST;
        end
      end
      S_DIV_LAST: begin
        if (div_done) begin
          last_t_d   = div_quot;
          total_cm_d = new_total_cm;
          total_ms_d = new_total_ms;
          state_d    = S_DIV_DELTA;
        end
      end
      S_DIV_DELTA: begin
        if (div_done) begin
          dq_d    = DQ_W'(div_quot);
          state_d = S_DIV_SPEECH;
        end
      end
      S_DIV_SPEECH: begin
        if (div_done) begin
          // a multiple is crossed when the old remainder plus the advance reaches the step
          speech_d = (speech_step_q != '0) && (dq_q != '0)
                  && ((EV_W'(div_rem) + EV_W'(dq_q)) >= EV_W'(speech_step_q));
          state_d  = S_DIV_HAPTIC;
        end
      end
      S_DIV_HAPTIC: begin
        if (div_done) begin
          haptic_d = (haptic_step_q != '0) && (dq_q != '0)
                  && ((EV_W'(div_rem) + EV_W'(dq_q)) >= EV_W'(haptic_step_q));
          state_d  = full ? S_FULL_RD : S_WRITE;
        end
      end
      S_FULL_RD: begin
        state_d = S_FULL_POP;
      end
      S_FULL_POP: begin
        // every window holding the whole store loses its oldest entry
        for (int w = 0; w < 2; w++) begin
          if (win_q[w].count == live_q) begin
            win_d[w].cm    = win_q[w].cm - WSUM_CM_W'(rd_data_q.cm);
            win_d[w].ms    = win_q[w].ms - WSUM_MS_W'(rd_data_q.ms);
            win_d[w].head  = next_slot(win_q[w].head);
            win_d[w].count = win_q[w].count - 1'b1;
          end
        end
        dropped_d = 1'b1;
        state_d   = S_WRITE;
      end
      S_WRITE: begin
        tail_d = next_slot(tail_q);
        for (int w = 0; w < 2; w++) begin
          if (win_q[w].count == '0) begin
            win_d[w].head = tail_q;
          end
          win_d[w].count = win_q[w].count + 1'b1;
          win_d[w].cm    = win_q[w].cm + WSUM_CM_W'(cm_q);
          win_d[w].ms    = win_q[w].ms + WSUM_MS_W'(ms_q);
        end
        sel_d   = WIN_SHORT;
        state_d = S_WIN_RD;
      end
      S_WIN_RD: begin
        state_d = S_WIN_EV;
      end
      S_WIN_EV: begin
        if (pop_ok) begin
          win_d[sel_q].cm    = win_cur.cm - WSUM_CM_W'(rd_data_q.cm);
          win_d[sel_q].ms    = win_cur.ms - WSUM_MS_W'(rd_data_q.ms);
          win_d[sel_q].head  = next_slot(win_cur.head);
          win_d[sel_q].count = win_cur.count - 1'b1;
        end else if (sel_q == WIN_SHORT) begin
          sel_d   = WIN_LONG;
          state_d = S_WIN_RD;
        end else begin
          state_d = S_RESP;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      tail_q     <= '0;
      live_q     <= '0;
      total_cm_q <= '0;
      total_ms_q <= '0;
      win_q[0]   <= '0;
      win_q[1]   <= '0;
      sel_q      <= WIN_SHORT;
      last_t_q   <= '0;
      dq_q       <= '0;
      speech_q   <= 1'b0;
      haptic_q   <= 1'b0;
      dropped_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      tail_q     <= tail_d;
      live_q     <= live_d;
      total_cm_q <= total_cm_d;
      total_ms_q <= total_ms_d;
      win_q      <= win_d;
      sel_q      <= sel_d;
      last_t_q   <= last_t_d;
      dq_q       <= dq_d;
      speech_q   <= speech_d;
      haptic_q   <= haptic_d;
      dropped_q  <= dropped_d;
    end
  end

  // request payload capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cm_q <= increment_cm_i;
      ms_q <= increment_ms_i;
    end
  end

  // register writes, indexes past the list are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q        <= UNIT_RST;
      short_win_q   <= SHORT_RST;
      speech_step_q <= SPEECH_RST;
      haptic_step_q <= HAPTIC_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_UNIT_LENGTH:  unit_q        <= cfg_data_i;
        CFG_SHORT_WINDOW: short_win_q   <= cfg_data_i[SHORT_W-1:0];
        CFG_SPEECH_STEP:  speech_step_q <= cfg_data_i[STEP_W-1:0];
        CFG_HAPTIC_STEP:  haptic_step_q <= cfg_data_i[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // result, held in state registers and shown in the strobe cycle
  assign total_distance_cm_o = total_cm_q;
  assign total_time_ms_o     = total_ms_q;
  assign short_sum_cm_o      = sat_out(WSUM_MS_W'(win_q[WIN_SHORT].cm));
  assign short_sum_ms_o      = sat_out(win_q[WIN_SHORT].ms);
  assign long_sum_cm_o       = sat_out(WSUM_MS_W'(win_q[WIN_LONG].cm));
  assign long_sum_ms_o       = sat_out(win_q[WIN_LONG].ms);
  assign speech_event_o      = speech_q;
  assign haptic_event_o      = haptic_q;
  assign entry_dropped_o     = dropped_q;

  // an accepted request either starts work or answers at once
  `ASSERT_NEXT(a_req_progress, clk_i, rst_ni, accept, busy || done_o)
  // a forced drop is only reported while the store is full
  `ASSERT_IMPLIES(a_drop_when_full, clk_i, rst_ni, done_o && entry_dropped_o, live_q == CNT_W'(STORE_DEPTH))
  // no window ever holds more entries than the store
  `ASSERT_ALWAYS(a_win_bound, clk_i, rst_ni, (win_q[WIN_SHORT].count <= CNT_W'(STORE_DEPTH)) && (win_q[WIN_LONG].count <= CNT_W'(STORE_DEPTH)))
  // divider results only arrive while the sequencer waits for them
  `ASSERT_IMPLIES(a_div_expected, clk_i, rst_ni, div_done, (state_q == S_DIV_LAST) || (state_q == S_DIV_DELTA) || (state_q == S_DIV_SPEECH) || (state_q == S_DIV_HAPTIC))

endmodule
